// ===== hdl/drq_pkg.sv =====
// ----------------------------------------------------------------------------
// drq_pkg: shared types and codes of the request queue
// Field widths, command and status codes, the entry and result records,
// and the sequencer state type.
// ----------------------------------------------------------------------------
package drq_pkg;

    localparam int CMD_W     = 2;
    localparam int STATION_W = 5;
    localparam int KIND_W    = 2;
    localparam int TIME_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 6;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0]    time_stamp;
        logic [KIND_W-1:0]    kind;
        logic [STATION_W-1:0] station;
    } entry_t;

    typedef struct packed {
        entry_t              head;
        logic                head_valid;
        logic [OCC_W-1:0]    occupancy;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_APPEND = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

endpackage

// ===== hdl/drq_entry_store.sv =====
// ----------------------------------------------------------------------------
// drq_entry_store: entry memory of the request queue
// One write port and one registered read port, plus a copy of the entry
// at position zero so that the oldest entry is always at hand.
// ----------------------------------------------------------------------------
module drq_entry_store
    import drq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_WIDTH  = 16
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    input  entry_t                         wr_entry,
    input  logic                           rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    output entry_t                         rd_entry,
    output entry_t                         head_entry
);

    localparam int STW = (TIME_WIDTH < TIME_W) ? TIME_WIDTH : TIME_W;
    localparam int EW  = STATION_W + KIND_W + STW;

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [EW-1:0] head_reg;
    logic [EW-1:0] wr_word;

    assign wr_word = {wr_entry.time_stamp[STW-1:0], wr_entry.kind, wr_entry.station};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en && (wr_addr == '0)) begin
            head_reg <= wr_word;
        end
    end

    assign rd_entry.station    = rd_data_reg[STATION_W-1:0];
    assign rd_entry.kind       = rd_data_reg[STATION_W +: KIND_W];
    assign rd_entry.time_stamp = TIME_W'(rd_data_reg[EW-1:STATION_W+KIND_W]);

    assign head_entry.station    = head_reg[STATION_W-1:0];
    assign head_entry.kind       = head_reg[STATION_W +: KIND_W];
    assign head_entry.time_stamp = TIME_W'(head_reg[EW-1:STATION_W+KIND_W]);

endmodule

// ===== hdl/drq_seq.sv =====
// ----------------------------------------------------------------------------
// drq_seq: search and shift sequencer of the request queue
// Walks the held entries one per cycle through the store's read port and a
// single station and kind comparator, then appends, closes a gap, or
// reports, and hands one result record to the output stage.
// ----------------------------------------------------------------------------
module drq_seq
    import drq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [CMD_W-1:0]               in_command,
    input  entry_t                         in_entry,
    output logic                           wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    output entry_t                         wr_entry,
    output logic                           rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    input  entry_t                         rd_entry,
    input  entry_t                         head_entry,
    output logic                           res_valid,
    input  logic                           res_ready,
    output result_t                        res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    state_t               state_reg,  state_next;
    logic [CMD_W-1:0]     cmd_reg,    cmd_next;
    entry_t               key_reg,    key_next;
    logic [CW-1:0]        count_reg,  count_next;
    logic [AW-1:0]        idx_reg,    idx_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 match;
    logic                 last;
    logic [CW-1:0]        idx_ext;

    assign idx_ext = CW'(idx_reg);
    assign last    = (idx_ext == (count_reg - CW'(1)));
    assign match   = (rd_entry.station == key_reg.station) && (rd_entry.kind == key_reg.kind);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign rd_addr   = (state_reg == S_IDLE) ? '0 : (idx_reg + AW'(1));

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg - AW'(1);
        wr_entry    = rd_entry;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next = in_command;
                    key_next = in_entry;
                    idx_next = '0;
                    case (in_command)
                        CMD_INSERT: begin
                            if (count_reg == '0) begin
                                state_next = S_APPEND;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_RESULT;
                            end else begin
                                rd_en      = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            count_next  = '0;
                            status_next = ST_CLEARED;
                            state_next  = S_RESULT;
                        end
                        default: begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_RESULT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    if (cmd_reg == CMD_INSERT) begin
                        status_next = ST_DUPLICATE;
                        state_next  = S_RESULT;
                    end else if (last) begin
                        count_next  = count_reg - CW'(1);
                        status_next = ST_DELETED;
                        state_next  = S_RESULT;
                    end else begin
                        rd_en      = 1'b1;
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_SHIFT;
                    end
                end else if (last) begin
                    if (cmd_reg != CMD_INSERT) begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESULT;
                    end else if (count_reg == CW'(QUEUE_DEPTH)) begin
                        status_next = ST_FULL;
                        state_next  = S_RESULT;
                    end else begin
                        state_next = S_APPEND;
                    end
                end else begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_SHIFT: begin
                wr_en = 1'b1;
                if (last) begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_DELETED;
                    state_next  = S_RESULT;
                end else begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_APPEND: begin
                wr_en       = 1'b1;
                wr_addr     = count_reg[AW-1:0];
                wr_entry    = key_reg;
                count_next  = count_reg + CW'(1);
                status_next = ST_INSERTED;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status     = status_reg;
        res.occupancy  = OCC_W'(count_reg);
        res.head_valid = (count_reg != '0);
        res.head       = (count_reg != '0) ? head_entry : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("Queue occupancy exceeds its depth.");

    a_index_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN || state_reg == S_SHIFT) |-> (idx_ext < count_reg))
        else $error("Walk index points past the held entries.");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_APPEND) |=> (count_reg == ($past(count_reg) + CW'(1))))
        else $error("Append did not grow the queue by one entry.");

    a_insert_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.status == ST_INSERTED) |-> res.head_valid)
        else $error("Insert reported with an empty queue.");

endmodule

// ===== hdl/dedup_request_queue.sv =====
// One request is in work at a time: a new transfer is taken only once the sequencer is idle
// again. An insert or delete walks the held entries in the entry memory, one entry per cycle,
// and an appending insert then writes the new entry; a clear or an unused command needs no walk.
// Reset (aresetn low, synchronous) empties the queue; entry contents are not cleared.
// A result waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
// dedup_request_queue: ordered request queue with duplicate suppression
// Holds (station, kind, time) entries in arrival order, drops duplicate
// inserts, removes matching entries while keeping order, and reports status,
// occupancy and the oldest entry for every request.
// ----------------------------------------------------------------------------
module dedup_request_queue
    import drq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_WIDTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // station [4:0], request_kind [6:5], time_stamp [22:7], zeros above
    input  logic [23:0] s_axis_tdata,
    // command [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status [2:0], occupancy [8:3], head_station [13:9], head_kind [15:14],
    // head_time [31:16]
    output logic [31:0] m_axis_tdata,
    // head_valid [0]
    output logic [0:0]  m_axis_tuser
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    entry_t          in_entry;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    entry_t          wr_entry;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    entry_t          rd_entry;
    entry_t          head_entry;
    logic            res_valid;
    logic            res_ready;
    result_t         res;
    result_t         out_reg;
    logic            out_valid_reg;

    assign in_entry.station    = s_axis_tdata[STATION_W-1:0];
    assign in_entry.kind       = s_axis_tdata[STATION_W +: KIND_W];
    assign in_entry.time_stamp = s_axis_tdata[STATION_W+KIND_W +: TIME_W];

    drq_entry_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_store (
        .aclk       (aclk),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_entry   (wr_entry),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_entry),
        .head_entry (head_entry)
    );

    drq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser),
        .in_entry   (in_entry),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_entry   (wr_entry),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_entry),
        .head_entry (head_entry),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_reg.head.time_stamp, out_reg.head.kind,
                              out_reg.head.station, out_reg.occupancy, out_reg.status};
    assign m_axis_tuser[0] = out_reg.head_valid;

endmodule

// ===== tb/drq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drq_checker: result checker of the request queue
// Watches both stream channels. Every accepted request is applied to a
// shadow copy of the queue, which gives the result that the request must
// produce. Every accepted result is compared field by field with the oldest
// result still owed, and the count of mismatches goes to the testbench top.
// ----------------------------------------------------------------------------
module drq_checker
    import drq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          replies_owed,
    output int          mismatch_count
);

    entry_t  held[QUEUE_DEPTH];
    int      held_count;
    result_t replies_due[$];
    int      errors;

    function automatic int find_held(entry_t key);
        for (int i = 0; i < held_count; i++) begin
            if (held[i].station == key.station && held[i].kind == key.kind) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow queue and returns the result it causes.
    function automatic result_t apply_request(logic [CMD_W-1:0] cmd, entry_t req);
        result_t r;
        int      pos;
        r   = '0;
        pos = find_held(req);
        case (cmd)
            CMD_INSERT: begin
                if (pos >= 0) begin
                    r.status = ST_DUPLICATE;
                end else if (held_count >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    held[held_count] = req;
                    held_count++;
                    r.status = ST_INSERTED;
                end
            end
            CMD_DELETE: begin
                if (pos < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = pos; i < held_count - 1; i++) begin
                        held[i] = held[i + 1];
                    end
                    held_count--;
                    r.status = ST_DELETED;
                end
            end
            CMD_CLEAR: begin
                held_count = 0;
                r.status   = ST_CLEARED;
            end
            default: begin
                r.status = ST_NOT_FOUND;
            end
        endcase
        r.occupancy = OCC_W'(held_count);
        if (held_count > 0) begin
            r.head_valid = 1'b1;
            r.head       = held[0];
        end
        return r;
    endfunction

    function automatic void check_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        result_t seen;
        result_t want;
        entry_t  req;
        if (!aresetn) begin
            held_count = 0;
            replies_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.status       = m_axis_tdata[2:0];
                seen.occupancy    = m_axis_tdata[8:3];
                seen.head.station = m_axis_tdata[13:9];
                seen.head.kind    = m_axis_tdata[15:14];
                seen.head.time_stamp = m_axis_tdata[31:16];
                seen.head_valid   = m_axis_tuser[0];
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, seen.status);
                    check_field("occupancy", want.occupancy, seen.occupancy);
                    check_field("head_valid", want.head_valid, seen.head_valid);
                    check_field("head_station", want.head.station, seen.head.station);
                    check_field("head_kind", want.head.kind, seen.head.kind);
                    check_field("head_time", want.head.time_stamp, seen.head.time_stamp);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.station    = s_axis_tdata[4:0];
                req.kind       = s_axis_tdata[6:5];
                req.time_stamp = s_axis_tdata[22:7];
                replies_due.push_back(apply_request(s_axis_tuser, req));
            end
        end
        replies_owed   <= replies_due.size();
        mismatch_count <= errors;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the request queue with duplicate suppression
// Drives a short directed sequence of inserts, deletes, clears and the unused
// command, then phases of random requests that fill, churn and drain the
// queue, with random idle bursts on both channels. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import drq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 1330;
    localparam int CALM_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 60;

    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    int replies_owed;
    int mismatch_count;

    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    logic [6:0] sent_keys[$];

    always #5 aclk = ~aclk;

    dedup_request_queue #(
        .QUEUE_DEPTH(32),
        .TIME_WIDTH (16)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    drq_checker #(
        .QUEUE_DEPTH(32)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .replies_owed  (replies_owed),
        .mismatch_count(mismatch_count)
    );

    initial begin
        int hold;
        forever begin
            @(posedge aclk);
            if (stalls_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [4:0] stn, logic [1:0] kind,
                                logic [15:0] stamp);
        int hold;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (hold) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, stamp, kind, stn};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (replies_owed != 0);
    endtask

    task automatic random_request(mix_t mix);
        int         roll;
        int         ins_pct;
        int         pick;
        logic [CMD_W-1:0] cmd;
        logic [6:0] key;
        case (mix)
            MIX_FILL:  ins_pct = 86;
            MIX_CHURN: ins_pct = 50;
            default:   ins_pct = 18;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < ins_pct) begin
            cmd = CMD_INSERT;
        end else if (roll < 98) begin
            cmd = CMD_DELETE;
        end else if (roll == 98) begin
            cmd = CMD_CLEAR;
        end else begin
            cmd = CMD_SPARE;
        end
        if ($urandom_range(0, 1) == 0) begin
            key = {3'b000, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
        end else begin
            key = 7'($urandom_range(0, 127));
        end
        pick = -1;
        if (sent_keys.size() > 0) begin
            if ((cmd == CMD_DELETE && $urandom_range(0, 3) != 0) ||
                (cmd == CMD_INSERT && $urandom_range(0, 4) == 0)) begin
                pick = $urandom_range(0, sent_keys.size() - 1);
                key  = sent_keys[pick];
            end
        end
        if (cmd == CMD_INSERT && pick < 0) begin
            sent_keys.push_back(key);
            if (sent_keys.size() > 64) begin
                void'(sent_keys.pop_front());
            end
        end else if (cmd == CMD_DELETE && pick >= 0) begin
            sent_keys.delete(pick);
        end else if (cmd == CMD_CLEAR) begin
            sent_keys.delete();
        end
        send_request(cmd, key[6:2], key[1:0], 16'($urandom_range(0, 65535)));
    endtask

    initial begin
        int   done;
        int   span;
        mix_t mix;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty queue, extremes, duplicates, order keeping.
        send_request(CMD_DELETE, 5'd5,  2'd1, 16'h0000);
        send_request(CMD_SPARE,  5'd0,  2'd0, 16'h0000);
        send_request(CMD_CLEAR,  5'd0,  2'd0, 16'h0000);
        send_request(CMD_INSERT, 5'd31, 2'd3, 16'hFFFF);
        send_request(CMD_INSERT, 5'd0,  2'd0, 16'h0000);
        send_request(CMD_INSERT, 5'd31, 2'd3, 16'h1234);
        send_request(CMD_INSERT, 5'd31, 2'd2, 16'hAAAA);
        send_request(CMD_INSERT, 5'd30, 2'd3, 16'h5555);
        send_request(CMD_INSERT, 5'd0,  2'd1, 16'h8001);
        send_request(CMD_DELETE, 5'd31, 2'd3, 16'hFFFF);
        send_request(CMD_DELETE, 5'd0,  2'd0, 16'h0000);
        send_request(CMD_INSERT, 5'd31, 2'd3, 16'h7FFF);
        send_request(CMD_DELETE, 5'd30, 2'd3, 16'h0F0F);
        send_request(CMD_DELETE, 5'd31, 2'd3, 16'hF0F0);
        send_request(CMD_DELETE, 5'd31, 2'd3, 16'h0000);
        send_request(CMD_SPARE,  5'd0,  2'd1, 16'hFFFF);
        send_request(CMD_INSERT, 5'd0,  2'd1, 16'h4321);
        send_request(CMD_INSERT, 5'd16, 2'd1, 16'h8000);
        send_request(CMD_CLEAR,  5'd31, 2'd3, 16'hFFFF);
        send_request(CMD_DELETE, 5'd16, 2'd1, 16'h0000);
        send_request(CMD_INSERT, 5'd21, 2'd2, 16'h00FF);
        send_request(CMD_CLEAR,  5'd0,  2'd0, 16'h0000);
        wait_for_replies();

        // Random part: phases with their own command mix and idle pattern.
        done = 0;
        mix  = MIX_FILL;
        span = 80;
        while (done < RANDOM_ITEMS) begin
            for (int k = 0; k < span && done < RANDOM_ITEMS; k++) begin
                if (done >= RANDOM_ITEMS - CALM_ITEMS) begin
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end
                random_request(mix);
                done++;
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_for_replies();
            end
            mix       = mix_t'($urandom_range(0, 2));
            span      = $urandom_range(30, 90);
            if (done < RANDOM_ITEMS - CALM_ITEMS) begin
                gaps_on   = $urandom_range(0, 9) < 6;
                stalls_on = $urandom_range(0, 9) < 6;
            end
        end

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/drq_pkg.sv
hdl/drq_entry_store.sv
hdl/drq_seq.sv
hdl/dedup_request_queue.sv
tb/drq_checker.sv
tb/tb.sv
